// ===== rtl/tidpd_pkg.sv =====
// Shared constants, codes and types for the tunnel immersion and piston drag block.
package tidpd_pkg;

  localparam int MAX_ZONES = 16;
  localparam int ZIDX_W    = (MAX_ZONES > 1) ? $clog2(MAX_ZONES) : 1;
  localparam int CNT_W     = $clog2(MAX_ZONES + 1);
  // Each overlap is at most twice the train length, which stays below 2^19.
  localparam int OV_W      = 19;
  localparam int SUM_W     = ZIDX_W + OV_W;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_ADD   = 2'd1;
  localparam logic [1:0] CMD_STEP  = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_IGNORED = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TUNNEL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TRAIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RHO    = 3'd4;

  localparam logic [16:0] IMM_ONE   = 17'd65536;
  localparam logic [17:0] MIN_LEN   = 18'd100;
  localparam logic [13:0] MIN_AREA  = 14'd16;

  typedef struct packed {
    logic [16:0] imm;
    logic [15:0] vmag;
    logic [13:0] consist_area;
    logic [13:0] bore_area;
    logic [15:0] gain;
    logic [11:0] rho;
  } drag_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] drag;
  } drag_rsp_t;

endpackage

// ===== rtl/tidpd_if.sv =====
// Channel interfaces: input items, result items and configuration writes.
interface tidpd_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic signed [31:0] zone_start;
  logic signed [31:0] zone_end;
  logic signed [31:0] train_center;
  logic [17:0]        consist_length;
  logic signed [15:0] speed;
  logic [19:0]        time_step;
  modport source (output valid, cmd, zone_start, zone_end, train_center, consist_length,
                  speed, time_step, input ready);
  modport sink (input valid, cmd, zone_start, zone_end, train_center, consist_length,
                speed, time_step, output ready);
endinterface

interface tidpd_out_if;
  logic        valid;
  logic        ready;
  logic [16:0] immersion_frac;
  logic [31:0] drag_force;
  logic [1:0]  status;
  modport source (output valid, immersion_frac, drag_force, status, input ready);
  modport sink (input valid, immersion_frac, drag_force, status, output ready);
endinterface

interface tidpd_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/tidpd_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module tidpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic                                         re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ===== rtl/tidpd_drag.sv =====
// Piston drag: serial 128-bit product chain followed by a restoring divider.
module tidpd_drag import tidpd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  drag_req_t req,
  output drag_rsp_t rsp
);
  localparam logic [2:0] D_IDLE = 3'd0;
  localparam logic [2:0] D_PRE  = 3'd1;
  localparam logic [2:0] D_DEN  = 3'd2;
  localparam logic [2:0] D_MUL  = 3'd3;
  localparam logic [2:0] D_CHK  = 3'd4;
  localparam logic [2:0] D_DIV  = 3'd5;

  logic [2:0]   st_r;
  drag_req_t    req_r;
  logic [27:0]  bnum_r, bden_r;
  logic [41:0]  den_r;
  logic [31:0]  vsq_r;
  logic [127:0] acc_r;
  logic [31:0]  carry_r;
  logic [1:0]   pass_r, limb_r;
  logic [88:0]  rem_r;
  logic [72:0]  dsh_r;
  logic [31:0]  q_r;
  logic [4:0]   it_r;
  logic         done_r;
  logic [31:0]  drag_r;

  logic [13:0]  ta_c, tu_c;
  logic         blk;
  logic [31:0]  mul_m;
  logic [63:0]  prod;
  logic [88:0]  y;
  logic         sat;
  logic         take;
  logic [31:0]  q_nxt;

  always_comb begin
    ta_c = (req_r.consist_area < MIN_AREA) ? MIN_AREA : req_r.consist_area;
    tu_c = (req_r.bore_area < MIN_AREA) ? MIN_AREA : req_r.bore_area;
    blk  = (18'(ta_c) * 18'd10) >= (18'(tu_c) * 18'd9);
    case (pass_r)
      2'd0:    mul_m = 32'(ta_c);
      2'd1:    mul_m = 32'(req_r.imm);
      2'd2:    mul_m = 32'(bnum_r);
      default: mul_m = vsq_r;
    endcase
    prod  = 64'(acc_r[limb_r*32 +: 32]) * 64'(mul_m) + 64'(carry_r);
    y     = acc_r[127:39];
    // A quotient of 2^32 or more saturates.
    sat   = y >= 89'({den_r, 32'd0});
    take  = rem_r >= 89'(dsh_r);
    q_nxt = {q_r[30:0], take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= D_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= (st_r == D_CHK && sat) || (st_r == D_DIV && it_r == 5'd31);
      case (st_r)
        D_IDLE: begin
          if (start) begin
            req_r <= req;
            st_r  <= D_PRE;
          end
        end
        D_PRE: begin
          bnum_r <= blk ? 28'd81 : 28'(ta_c) * 28'(ta_c);
          bden_r <= blk ? 28'd100 : 28'(tu_c) * 28'(tu_c);
          st_r   <= D_DEN;
        end
        D_DEN: begin
          den_r   <= 42'(bden_r) * 42'd10000;
          vsq_r   <= 32'(req_r.vmag) * 32'(req_r.vmag);
          acc_r   <= {100'd0, 28'(req_r.gain) * 28'(req_r.rho)};
          carry_r <= '0;
          pass_r  <= '0;
          limb_r  <= '0;
          st_r    <= D_MUL;
        end
        D_MUL: begin
          acc_r[limb_r*32 +: 32] <= prod[31:0];
          limb_r                 <= limb_r + 2'd1;
          if (limb_r == 2'd3) begin
            carry_r <= '0;
            pass_r  <= pass_r + 2'd1;
            if (pass_r == 2'd3) begin
              st_r <= D_CHK;
            end
          end else begin
            carry_r <= prod[63:32];
          end
        end
        D_CHK: begin
          if (sat) begin
            drag_r <= 32'hFFFF_FFFF;
            st_r   <= D_IDLE;
          end else begin
            rem_r <= y;
            dsh_r <= {den_r, 31'd0};
            q_r   <= '0;
            it_r  <= '0;
            st_r  <= D_DIV;
          end
        end
        D_DIV: begin
          if (take) begin
            rem_r <= rem_r - 89'(dsh_r);
          end
          dsh_r <= dsh_r >> 1;
          q_r   <= q_nxt;
          it_r  <= it_r + 5'd1;
          if (it_r == 5'd31) begin
            drag_r <= q_nxt;
            st_r   <= D_IDLE;
          end
        end
        default: st_r <= D_IDLE;
      endcase
    end
  end

  assign rsp.done = done_r;
  assign rsp.drag = drag_r;

  a_done_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> ($past(st_r) == D_CHK || $past(st_r) == D_DIV))
    else $error("drag done without a finishing step");
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == D_IDLE && start) |=> st_r == D_PRE)
    else $error("drag start not taken");
  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == D_DIV |-> rem_r < 89'({den_r, 32'd0}))
    else $error("drag remainder out of range");
endmodule

// ===== rtl/tunnel_immersion_and_piston_drag.sv =====
// Top level: zone table in RAM, immersion walk and divide, drag unit and result register.
// Clear, add and ignored commands pass from input transfer through state S_FIN to the output register.
// A step walks the zone RAM, reading each zone in S_RD (registered read) and adding its overlap in S_ACC,
// runs the immersion divide (skipped at full immersion or with an empty table) and then the drag unit.
// One item is in work at a time; the next is taken while a result waits in the output register.
// Synchronous active-low reset empties the zone table, zeroes immersion, loads register defaults.
module tunnel_immersion_and_piston_drag import tidpd_pkg::*; (
  input logic         clk,
  input logic         rst_n,
  tidpd_in_if.sink    in_ch,
  tidpd_out_if.source out_ch,
  tidpd_cfg_if.sink   cfg_ch
);
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_RD     = 3'd1;
  localparam logic [2:0] S_ACC    = 3'd2;
  localparam logic [2:0] S_DIV    = 3'd3;
  localparam logic [2:0] S_LAUNCH = 3'd4;
  localparam logic [2:0] S_DRAG   = 3'd5;
  localparam logic [2:0] S_FIN    = 3'd6;

  logic        en_r;
  logic [13:0] tu_r, ta_r;
  logic [15:0] gain_r;
  logic [11:0] rho_r;

  logic [2:0]        state_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [16:0]       lvl_r;
  logic [ZIDX_W-1:0] idx_r;
  logic [SUM_W-1:0]  sum_r;
  logic [18:0]       l2_r;
  logic [17:0]       len_r;
  logic signed [31:0] ctr_r;
  logic [15:0]       vmag_r;
  logic [18:0]       rem_r;
  logic [15:0]       q_r;
  logic [3:0]        it_r;
  logic [1:0]        res_status_r;
  logic [31:0]       res_drag_r;

  logic        out_valid_r;
  logic [16:0] out_imm_r;
  logic [31:0] out_drag_r;
  logic [1:0]  out_status_r;

  logic        in_fire, ram_we, ram_re, last_zone;
  logic        step_go;
  logic [1:0]  in_status;
  logic [63:0] ram_rdata;
  logic [17:0] len_c;
  logic [15:0] vmag_c;
  logic signed [34:0] c2, lenx, head, tail, hi, lo, mn, mx, ov;
  logic [SUM_W-1:0] sum_nxt;
  logic [19:0] rsh;
  drag_req_t drg_req;
  drag_rsp_t drg_rsp;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    len_c  = (in_ch.consist_length < MIN_LEN) ? MIN_LEN : in_ch.consist_length;
    vmag_c = in_ch.speed[15] ? 16'(-in_ch.speed) : in_ch.speed;
    ram_we = in_fire && (in_ch.cmd == CMD_ADD) && (in_ch.zone_end > in_ch.zone_start)
             && (cnt_r != CNT_W'(MAX_ZONES));
    step_go = en_r && (in_ch.time_step != 20'd0);
    case (in_ch.cmd)
      CMD_CLEAR: in_status = ST_OK;
      CMD_ADD: begin
        // The invalid-zone check comes before the full-table check.
        if (!(in_ch.zone_end > in_ch.zone_start)) begin
          in_status = ST_INVALID;
        end else if (cnt_r == CNT_W'(MAX_ZONES)) begin
          in_status = ST_FULL;
        end else begin
          in_status = ST_OK;
        end
      end
      CMD_STEP: in_status = step_go ? ST_OK : ST_IGNORED;
      default:  in_status = ST_IGNORED;
    endcase
    ram_re = (state_r == S_RD);
    c2   = {{2{ctr_r[31]}}, ctr_r, 1'b0};
    lenx = 35'(len_r);
    head = c2 + lenx;
    tail = c2 - lenx;
    hi   = {{2{ram_rdata[63]}}, ram_rdata[63:32], 1'b0};
    lo   = {{2{ram_rdata[31]}}, ram_rdata[31:0], 1'b0};
    mn   = (head < hi) ? head : hi;
    mx   = (tail > lo) ? tail : lo;
    ov   = mn - mx;
    sum_nxt   = (ov > 35'sd0) ? sum_r + SUM_W'(ov[OV_W-1:0]) : sum_r;
    last_zone = (CNT_W'(idx_r) + CNT_W'(1)) == cnt_r;
    rsh       = {rem_r, 1'b0};
  end

  tidpd_ram #(.WIDTH(64), .DEPTH(MAX_ZONES)) u_zone_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r[ZIDX_W-1:0]),
    .wdata ({in_ch.zone_end, in_ch.zone_start}),
    .re    (ram_re),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  assign drg_req = '{imm: lvl_r, vmag: vmag_r, consist_area: ta_r, bore_area: tu_r,
                     gain: gain_r, rho: rho_r};

  tidpd_drag u_drag (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == S_LAUNCH),
    .req   (drg_req),
    .rsp   (drg_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r   <= 1'b0;
      tu_r   <= MIN_AREA;
      ta_r   <= MIN_AREA;
      gain_r <= '0;
      rho_r  <= 12'd1254;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        REG_ENABLE: en_r   <= cfg_ch.data[0];
        REG_TUNNEL: tu_r   <= cfg_ch.data[13:0];
        REG_TRAIN:  ta_r   <= cfg_ch.data[13:0];
        REG_GAIN:   gain_r <= cfg_ch.data;
        REG_RHO:    rho_r  <= cfg_ch.data[11:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      lvl_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready && state_r != S_FIN) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            res_drag_r   <= '0;
            res_status_r <= in_status;
            case (in_ch.cmd)
              CMD_CLEAR: begin
                cnt_r   <= '0;
                state_r <= S_FIN;
              end
              CMD_ADD: begin
                if (ram_we) begin
                  cnt_r <= cnt_r + CNT_W'(1);
                end
                state_r <= S_FIN;
              end
              CMD_STEP: begin
                if (!step_go) begin
                  state_r <= S_FIN;
                end else begin
                  len_r  <= len_c;
                  l2_r   <= {len_c, 1'b0};
                  ctr_r  <= in_ch.train_center;
                  vmag_r <= vmag_c;
                  idx_r  <= '0;
                  sum_r  <= '0;
                  if (cnt_r == '0) begin
                    lvl_r   <= '0;
                    state_r <= S_LAUNCH;
                  end else begin
                    state_r <= S_RD;
                  end
                end
              end
              default: state_r <= S_FIN;
            endcase
          end
        end
        S_RD: state_r <= S_ACC;
        S_ACC: begin
          sum_r <= sum_nxt;
          idx_r <= idx_r + ZIDX_W'(1);
          if (last_zone) begin
            // Overlap at or above the train length clamps to full immersion.
            if (sum_nxt >= SUM_W'(l2_r)) begin
              lvl_r   <= IMM_ONE;
              state_r <= S_LAUNCH;
            end else begin
              rem_r   <= 19'(sum_nxt);
              q_r     <= '0;
              it_r    <= '0;
              state_r <= S_DIV;
            end
          end else begin
            state_r <= S_RD;
          end
        end
        S_DIV: begin
          if (rsh >= 20'(l2_r)) begin
            rem_r <= 19'(rsh - 20'(l2_r));
            q_r   <= {q_r[14:0], 1'b1};
          end else begin
            rem_r <= rsh[18:0];
            q_r   <= {q_r[14:0], 1'b0};
          end
          it_r <= it_r + 4'd1;
          if (it_r == 4'd15) begin
            lvl_r   <= 17'({q_r[14:0], rsh >= 20'(l2_r)});
            state_r <= S_LAUNCH;
          end
        end
        S_LAUNCH: state_r <= S_DRAG;
        S_DRAG: begin
          if (drg_rsp.done) begin
            res_drag_r <= drg_rsp.drag;
            state_r    <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r  <= 1'b1;
            out_imm_r    <= en_r ? lvl_r : '0;
            out_drag_r   <= res_drag_r;
            out_status_r <= res_status_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.immersion_frac = out_imm_r;
  assign out_ch.drag_force     = out_drag_r;
  assign out_ch.status         = out_status_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_ZONES))
    else $error("zone count above table size");
  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    lvl_r <= IMM_ONE)
    else $error("immersion above one");
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r != S_IDLE)
    else $error("input transfer left the sequencer idle");
  a_drag_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    drg_rsp.done |-> state_r == S_DRAG)
    else $error("drag result with no step waiting");
endmodule

// ===== verif/tb_tunnel_immersion_and_piston_drag.sv =====
// Self-checking testbench for the tunnel immersion and piston drag block.
`timescale 1ns / 1ps

module tb_tunnel_immersion_and_piston_drag;
  import tidpd_pkg::*;

  typedef struct {
    logic [1:0]         cmd;
    logic signed [31:0] zs;
    logic signed [31:0] ze;
    logic signed [31:0] center;
    logic [17:0]        len;
    logic signed [15:0] speed;
    logic [19:0]        dt;
  } rail_item_t;

  typedef struct {
    logic [16:0] imm;
    logic [31:0] drag;
    logic [1:0]  status;
  } drag_result_t;

  logic clk;
  logic rst_n;

  tidpd_in_if  in_ch();
  tidpd_out_if out_ch();
  tidpd_cfg_if cfg_ch();

  tunnel_immersion_and_piston_drag dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Shadow copy of the block's registers and zone table.
  logic               sh_enable;
  logic [13:0]        sh_tunnel;
  logic [13:0]        sh_train;
  logic [15:0]        sh_gain;
  logic [11:0]        sh_rho;
  logic signed [31:0] sh_zs [MAX_ZONES];
  logic signed [31:0] sh_ze [MAX_ZONES];
  int                 sh_count;
  logic [16:0]        sh_imm;

  rail_item_t   pending_items[$];
  drag_result_t awaited_results[$];
  rail_item_t   cur_item;
  int           gap_left;
  int           stall_left;
  int           fail_count;
  int           cycles;
  int           hold_at;
  bit           calm;
  bit           took;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_LEN    = 300;

  function automatic logic [31:0] piston_drag(logic [16:0] imm, logic [15:0] vmag);
    logic [127:0] ta, tu, bnum, bden, prod, quo;
    ta = (sh_train < MIN_AREA) ? 128'd16 : 128'(sh_train);
    tu = (sh_tunnel < MIN_AREA) ? 128'd16 : 128'(sh_tunnel);
    if (imm == 0) return 32'd0;
    if (ta * 10 >= tu * 9) begin
      bnum = 81;
      bden = 100;
    end else begin
      bnum = ta * ta;
      bden = tu * tu;
    end
    prod = 128'(sh_gain) * 128'(sh_rho);
    prod = prod * ta * 128'(imm) * bnum * 128'(vmag) * 128'(vmag);
    quo = (prod >> 39) / (bden * 128'd10000);
    return (quo > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : quo[31:0];
  endfunction

  // Applies one item to the shadow state and returns the result it should produce.
  function automatic drag_result_t advance_immersion(rail_item_t it);
    drag_result_t r;
    longint c2, len, head, tail, hi, lo, ov, covered, q;
    logic [15:0] vmag;
    r.drag = 0;
    r.status = ST_OK;
    case (it.cmd)
      CMD_CLEAR: sh_count = 0;
      CMD_ADD: begin
        if (!(it.ze > it.zs)) r.status = ST_INVALID;
        else if (sh_count >= MAX_ZONES) r.status = ST_FULL;
        else begin
          sh_zs[sh_count] = it.zs;
          sh_ze[sh_count] = it.ze;
          sh_count++;
        end
      end
      CMD_STEP: begin
        if (!sh_enable || it.dt == 0) begin
          r.status = ST_IGNORED;
        end else begin
          c2 = longint'(it.center) * 2;
          len = (it.len < MIN_LEN) ? 100 : longint'(it.len);
          vmag = (it.speed < 0) ? 16'(-int'(it.speed)) : 16'(it.speed);
          if (sh_count == 0) begin
            sh_imm = 0;
          end else begin
            head = c2 + len;
            tail = c2 - len;
            covered = 0;
            for (int i = 0; i < sh_count; i++) begin
              hi = longint'(sh_ze[i]) * 2;
              lo = longint'(sh_zs[i]) * 2;
              ov = ((head < hi) ? head : hi) - ((tail > lo) ? tail : lo);
              if (ov > 0) covered += ov;
            end
            q = (covered << 16) / (2 * len);
            sh_imm = (q > 65536) ? IMM_ONE : 17'(q);
          end
          r.drag = piston_drag(sh_imm, vmag);
        end
      end
      default: r.status = ST_IGNORED;
    endcase
    r.imm = sh_enable ? sh_imm : 17'd0;
    return r;
  endfunction

  // Input driver: holds an offered item until transfer, with random gaps between items.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      gap_left = 0;
    end else begin
      took = in_ch.valid && in_ch.ready;
      if (took) awaited_results = {awaited_results, advance_immersion(cur_item)};
      if (in_ch.valid && !took) begin
      end else if (gap_left > 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        cur_item = pending_items.pop_front();
        in_ch.cmd <= cur_item.cmd;
        in_ch.zone_start <= cur_item.zs;
        in_ch.zone_end <= cur_item.ze;
        in_ch.train_center <= cur_item.center;
        in_ch.consist_length <= cur_item.len;
        in_ch.speed <= cur_item.speed;
        in_ch.time_step <= cur_item.dt;
        in_ch.valid <= 1'b1;
        if (!calm && $urandom_range(0, 4) == 0) gap_left = $urandom_range(1, 4);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result monitor: compares every transfer with the oldest expectation.
  always @(posedge clk) begin
    drag_result_t e;
    if (!rst_n) begin
      out_ch.ready <= 1'b1;
      stall_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: result with nothing expected: imm %h drag %h status %h", $time,
                   out_ch.immersion_frac, out_ch.drag_force, out_ch.status);
          fail_count++;
        end else begin
          e = awaited_results.pop_front();
          if (out_ch.immersion_frac !== e.imm) begin
            $display("%0t: immersion_frac expected %h actual %h", $time, e.imm,
                     out_ch.immersion_frac);
            fail_count++;
          end
          if (out_ch.drag_force !== e.drag) begin
            $display("%0t: drag_force expected %h actual %h", $time, e.drag, out_ch.drag_force);
            fail_count++;
          end
          if (out_ch.status !== e.status) begin
            $display("%0t: status expected %h actual %h", $time, e.status, out_ch.status);
            fail_count++;
          end
        end
      end
      if (hold_at > 0 && cycles >= hold_at && cycles < hold_at + HOLD_LEN) begin
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (!calm && $urandom_range(0, 4) == 0) stall_left = $urandom_range(1, 4);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tunnel_immersion_and_piston_drag: mismatch");
      $finish;
    end
  end

  function automatic rail_item_t zone_add(logic signed [31:0] s, logic signed [31:0] e);
    rail_item_t it;
    it = '{cmd: CMD_ADD, zs: s, ze: e, center: $urandom, len: 18'($urandom),
           speed: 16'($urandom), dt: 20'($urandom)};
    return it;
  endfunction

  function automatic rail_item_t run_step(logic signed [31:0] c, logic [17:0] l,
                                          logic signed [15:0] v, logic [19:0] d);
    rail_item_t it;
    it = '{cmd: CMD_STEP, zs: $urandom, ze: $urandom, center: c, len: l, speed: v, dt: d};
    return it;
  endfunction

  function automatic rail_item_t bare_cmd(logic [1:0] c);
    rail_item_t it;
    it = '{cmd: c, zs: $urandom, ze: $urandom, center: $urandom, len: 18'($urandom),
           speed: 16'($urandom), dt: 20'($urandom)};
    return it;
  endfunction

  task automatic queue_item(rail_item_t it);
    pending_items = {pending_items, it};
  endtask

  // Mostly zones and train positions around one base point, so that steps see overlap.
  function automatic rail_item_t random_item(int base);
    int pick;
    int s;
    pick = $urandom_range(0, 99);
    s = base + $urandom_range(0, 100000) - 50000;
    if (pick < 5) return bare_cmd(CMD_CLEAR);
    if (pick < 8) return bare_cmd(2'd3);
    if (pick < 35) return zone_add(s, s + $urandom_range(1, 40000));
    if (pick < 38) return zone_add(s, s - $urandom_range(0, 100));
    if (pick < 40) return zone_add($urandom, $urandom);
    if (pick < 43) return run_step($urandom, 18'($urandom), 16'($urandom), 20'($urandom));
    if (pick < 46) return run_step(s, 18'($urandom_range(0, 20000)), 16'($urandom), 20'd0);
    if (pick < 50) return run_step(s, 18'($urandom), 16'($urandom),
                                   20'($urandom_range(1, 1048575)));
    return run_step(s, 18'($urandom_range(0, 30000)), 16'($urandom),
                    20'($urandom_range(1, 1048575)));
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      REG_ENABLE: sh_enable = data[0];
      REG_TUNNEL: sh_tunnel = data[13:0];
      REG_TRAIN:  sh_train = data[13:0];
      REG_GAIN:   sh_gain = data;
      REG_RHO:    sh_rho = data[11:0];
      default: ;
    endcase
  endtask

  task automatic drain;
    while (pending_items.size() > 0 || awaited_results.size() > 0 || in_ch.valid)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic load_regs(logic [15:0] en, logic [15:0] tu, logic [15:0] ta,
                           logic [15:0] g, logic [15:0] rho);
    write_reg(REG_ENABLE, en);
    write_reg(REG_TUNNEL, tu);
    write_reg(REG_TRAIN, ta);
    write_reg(REG_GAIN, g);
    write_reg(REG_RHO, rho);
  endtask

  task automatic random_phase(int n, int base);
    repeat (n) queue_item(random_item(base));
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= REG_ENABLE;
    cfg_ch.data <= '0;
    sh_enable = 1'b0;
    sh_tunnel = 14'd16;
    sh_train = 14'd16;
    sh_gain = 16'd0;
    sh_rho = 12'd1254;
    sh_count = 0;
    sh_imm = '0;
    fail_count = 0;
    cycles = 0;
    hold_at = 0;
    calm = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Disabled block: table edits still work, steps are ignored.
    queue_item(bare_cmd(CMD_CLEAR));
    queue_item(zone_add(0, 0));
    queue_item(zone_add(100, -100));
    queue_item(zone_add(32'h7FFF_FFFF, 32'h8000_0000));
    queue_item(zone_add(32'h8000_0000, 32'h7FFF_FFFF));
    queue_item(run_step(0, 1000, 500, 1000));
    queue_item(bare_cmd(2'd3));
    drain();

    // Largest areas, gain and density: the drag saturates.
    load_regs(16'd1, 16'd16383, 16'd16383, 16'hFFFF, 16'd4095);
    queue_item(run_step(0, 0, 16'sh8000, 20'hFFFFF));
    queue_item(run_step(0, 5000, 1000, 0));
    queue_item(run_step(32'h7FFF_FFFF, 18'h3FFFF, 16'sh7FFF, 1));
    queue_item(bare_cmd(CMD_CLEAR));
    queue_item(run_step(0, 200000, 20000, 1000));
    for (int i = 0; i < MAX_ZONES; i++)
      queue_item(zone_add(i * 1000, i * 1000 + 500));
    queue_item(zone_add(-50, 50));
    queue_item(run_step(32'h8000_0000, 99, 16'sh7FFF, 1));
    queue_item(run_step(8000, 16001, -20000, 1000));
    drain();

    // Small train in a large tunnel, so the blockage is the area ratio squared.
    load_regs(16'd1, 16'd800, 16'd160, 16'd256, 16'd1254);
    hold_at = cycles + 40;
    random_phase(90, 0);

    // Areas below the floor and zero density.
    load_regs(16'hFFFF, 16'd0, 16'd15, 16'($urandom), 16'd0);
    random_phase(60, 32'h7FFF_0000);

    // Random register contents over every bit, first disabled, then enabled.
    load_regs(16'hFFFE, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    random_phase(20, -1000000);
    load_regs(16'($urandom) | 16'd1, 16'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom));
    random_phase(90, 32'h8001_0000);

    load_regs(16'd1, 16'd2000, 16'd1900, 16'($urandom), 16'($urandom_range(1000, 1300)));
    random_phase(70, 5000);

    calm = 1'b1;
    load_regs(16'd1, 16'd3000, 16'd400, 16'($urandom), 16'($urandom));
    random_phase(70, 0);

    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("tunnel_immersion_and_piston_drag: match");
    end else begin
      $display("tunnel_immersion_and_piston_drag: mismatch");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/tidpd_pkg.sv
rtl/tidpd_if.sv
rtl/tidpd_ram.sv
rtl/tidpd_drag.sv
rtl/tunnel_immersion_and_piston_drag.sv
verif/tb_tunnel_immersion_and_piston_drag.sv
